// ===== hw/rtl/parabolic_sine_cosine_macros.svh =====
// ----------------------------------------------------------------------------
// parabolic_sine_cosine_macros
// Assertion macros used by the parabolic sine/cosine top module.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_SINE_COSINE_MACROS_SVH
`define PARABOLIC_SINE_COSINE_MACROS_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Constants and types of the parabolic sine/cosine pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  localparam int ANGLE_WIDTH_DEF  = 20;
  localparam int RESULT_WIDTH_DEF = 16;

  localparam int ANGLE_IN_W = 19;
  localparam int ANGLE_BYTES_W = 24;

  // reduced angle and parabola, signed, |v| <= 2^20
  localparam int XW = 22;

  localparam int Q14_PI      = 51472;
  localparam int Q14_TWO_PI  = 102944;
  localparam int Q14_HALF_PI = 25736;
  localparam int ANGLE_CLAMP = 1048576;

  localparam int Q16_FOUR_OVER_PI    = 83443;
  localparam int Q16_FOUR_OVER_PI_SQ = 26561;
  localparam int Q16_REFINE          = 14746;

  typedef logic signed [XW-1:0] xval_t;

endpackage

// ===== hw/rtl/parabolic_sine_cosine.sv =====
// ----------------------------------------------------------------------------
// parabolic_sine_cosine
// Parabolic sine/cosine approximation with quadratic refinement.
//
// Input stream: in_tdata carries the angle (signed Q5.14), in_tuser selects
// sine (0) or cosine (1). Output stream: out_tdata carries the value in
// signed Q1.(RESULT_WIDTH-1), saturated to +/-(2^(RESULT_WIDTH-1)-1).
// The pipeline has eleven register stages: wrap (1), parabola (5) and
// refinement (5), passed in order. Throughput is one item per cycle
// while out_tready is high; every stage is a plain register.
// Each stage holds its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles collapse and a stalled receiver only
// blocks input once all eleven stages are full.
// Reset clears all valid bits; out_tvalid is low after reset and in_tready
// is high. While out_tvalid is high and out_tready is low, out_tdata holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "parabolic_sine_cosine_macros.svh"

module parabolic_sine_cosine #(
  parameter int ANGLE_WIDTH  = psc_pkg::ANGLE_WIDTH_DEF,
  parameter int RESULT_WIDTH = psc_pkg::RESULT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [psc_pkg::ANGLE_BYTES_W-1:0]         in_tdata,   // angle
  input  logic [0:0]                                in_tuser,   // req_type
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((RESULT_WIDTH+7)/8)*8-1:0]         out_tdata   // value
);

  localparam int OUT_W = ((RESULT_WIDTH + 7) / 8) * 8;

  logic                           w_valid, w_ready;
  psc_pkg::xval_t                 w_x;
  logic                           p_valid, p_ready;
  psc_pkg::xval_t                 p_y;
  logic signed [RESULT_WIDTH-1:0] r_value;

  psc_wrap #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (in_tvalid),
    .s_ready  (in_tready),
    .req_type (in_tuser[0]),
    .angle    ($signed(in_tdata[psc_pkg::ANGLE_IN_W-1:0])),
    .m_valid  (w_valid),
    .m_ready  (w_ready),
    .x        (w_x)
  );

  psc_parab u_parab (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (w_valid),
    .s_ready (w_ready),
    .x       (w_x),
    .m_valid (p_valid),
    .m_ready (p_ready),
    .y       (p_y)
  );

  psc_refine #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_refine (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (p_valid),
    .s_ready (p_ready),
    .y       (p_y),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .value   (r_value)
  );

  assign out_tdata = OUT_W'($unsigned(r_value));

  `PSC_ASSERT_IMP(a_stall_source, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input blocked without output stall")
  `PSC_ASSERT_NXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, w_valid, "accepted item missing in first stage")
  `PSC_ASSERT_IMP(a_saturated, clk, rst_n, out_tvalid, out_tdata[RESULT_WIDTH-1:0] != {1'b1, {(RESULT_WIDTH-1){1'b0}}}, "value outside saturation range")

endmodule

// ===== hw/rtl/psc_wrap.sv =====
// ----------------------------------------------------------------------------
// psc_wrap
// Cosine offset, angle register wrap, one 2*pi fold and clamp; one stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_wrap #(
  parameter int ANGLE_WIDTH = psc_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  s_valid,
  output logic                                  s_ready,
  input  logic                                  req_type,
  input  logic signed [psc_pkg::ANGLE_IN_W-1:0] angle,
  output logic                                  m_valid,
  input  logic                                  m_ready,
  output psc_pkg::xval_t                        x
);

  localparam int WW = 35;
  localparam logic signed [WW-1:0] PI_W     = WW'(psc_pkg::Q14_PI);
  localparam logic signed [WW-1:0] TWO_PI_W = WW'(psc_pkg::Q14_TWO_PI);
  localparam logic signed [WW-1:0] CLAMP_W  = WW'(psc_pkg::ANGLE_CLAMP);

  logic signed [20:0]          sum21;
  logic signed [WW-1:0]        sum_w;
  logic signed [ANGLE_WIDTH-1:0] areg;
  logic signed [WW-1:0]        xe;
  logic signed [WW-1:0]        xw;
  logic signed [WW-1:0]        xc;
  logic                        v_r;
  logic                        en;
  psc_pkg::xval_t              x_r;
  psc_pkg::xval_t              x_nxt;

  always_comb begin
    sum21 = 21'(angle) + (req_type ? 21'(psc_pkg::Q14_HALF_PI) : 21'sd0);
    sum_w = WW'(sum21);
    areg  = ANGLE_WIDTH'(sum_w);
    xe    = WW'(areg);
    if (xe < -PI_W) begin
      xw = xe + TWO_PI_W;
    end else if (xe > PI_W) begin
      xw = xe - TWO_PI_W;
    end else begin
      xw = xe;
    end
    if (xw > CLAMP_W) begin
      xc = CLAMP_W;
    end else if (xw < -CLAMP_W) begin
      xc = -CLAMP_W;
    end else begin
      xc = xw;
    end
    x_nxt = xc[psc_pkg::XW-1:0];
  end

  assign en      = !v_r || m_ready;
  assign s_ready = en;
  assign m_valid = v_r;
  assign x       = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
    end
  end

endmodule

// ===== hw/rtl/psc_parab.sv =====
// ----------------------------------------------------------------------------
// psc_parab
// Parabola (4/pi)x - (4/pi^2)x|x| in Q44, rounded to Q20 and clamped to +/-1.
// Five stages: coefficient product, slope, split product, sum, round/clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_parab (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  psc_pkg::xval_t x,
  output logic           m_valid,
  input  logic           m_ready,
  output psc_pkg::xval_t y
);

  localparam int NS = 5;
  localparam int XW = psc_pkg::XW;
  localparam logic [14:0] C_SQ = 15'(psc_pkg::Q16_FOUR_OVER_PI_SQ);
  localparam logic signed [36:0] C_LIN = 37'(psc_pkg::Q16_FOUR_OVER_PI * 16384);
  localparam logic signed [58:0] HALF = 59'sd8388608;
  localparam logic signed [58:0] ONE  = 59'(psc_pkg::ANGLE_CLAMP);

  logic [NS-1:0]        v_r;
  logic [NS-1:0]        en;

  logic [XW-2:0]        ax;
  logic [35:0]          p_nxt, p_r;
  psc_pkg::xval_t       xa_r, xb_r;
  logic signed [36:0]   m_nxt, m_r;
  logic signed [40:0]   pplo_nxt, pplo_r, pphi_nxt, pphi_r;
  logic signed [58:0]   y44_nxt, y44_r;
  logic signed [58:0]   yr;
  psc_pkg::xval_t       y_nxt, y_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || m_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    ax       = (XW-1)'(x[XW-1] ? -x : x);
    p_nxt    = 36'(C_SQ) * 36'(ax);
    m_nxt    = C_LIN - $signed(37'(p_r));
    pplo_nxt = 41'(xb_r) * 41'($signed({1'b0, m_r[17:0]}));
    pphi_nxt = 41'(xb_r) * 41'($signed(m_r[36:18]));
    y44_nxt  = (59'(pphi_r) <<< 18) + 59'(pplo_r);
    yr       = (y44_r + HALF) >>> 24;
    if (yr > ONE) begin
      y_nxt = XW'(ONE);
    end else if (yr < -ONE) begin
      y_nxt = XW'(-ONE);
    end else begin
      y_nxt = XW'(yr);
    end
  end

  assign s_ready = en[0];
  assign m_valid = v_r[NS-1];
  assign y       = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= s_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r  <= p_nxt;
      xa_r <= x;
    end
    if (en[1]) begin
      m_r  <= m_nxt;
      xb_r <= xa_r;
    end
    if (en[2]) begin
      pplo_r <= pplo_nxt;
      pphi_r <= pphi_nxt;
    end
    if (en[3]) begin
      y44_r <= y44_nxt;
    end
    if (en[4]) begin
      y_r <= y_nxt;
    end
  end

endmodule

// ===== hw/rtl/psc_refine.sv =====
// ----------------------------------------------------------------------------
// psc_refine
// Refinement 0.225*(y|y| - y) + y in Q56, rounded half up and saturated.
// Five stages: gain product, gain offset, split product, sum, round/saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_refine #(
  parameter int RESULT_WIDTH = psc_pkg::RESULT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  psc_pkg::xval_t                 y,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic signed [RESULT_WIDTH-1:0] value
);

  localparam int NS = 5;
  localparam int XW = psc_pkg::XW;
  localparam int SH = 57 - RESULT_WIDTH;
  localparam logic signed [21:0] ONE_Y = 22'(psc_pkg::ANGLE_CLAMP);
  localparam logic signed [36:0] C_REF = 37'(psc_pkg::Q16_REFINE);
  localparam logic signed [37:0] OFFS  = 38'sd1 <<< 36;
  localparam logic signed [59:0] HALF  = 60'sd1 <<< (SH - 1);
  localparam logic signed [59:0] LIM   = (60'sd1 <<< (RESULT_WIDTH - 1)) - 60'sd1;

  logic [NS-1:0]                  v_r;
  logic [NS-1:0]                  en;

  logic [XW-2:0]                  ay;
  logic signed [21:0]             d;
  logic signed [36:0]             kk_nxt, kk_r;
  logic [36:0]                    k_nxt, k_r;
  psc_pkg::xval_t                 yf_r, yg_r;
  logic signed [41:0]             pplo_nxt, pplo_r, pphi_nxt, pphi_r;
  logic signed [59:0]             z_nxt, z_r;
  logic signed [59:0]             rz;
  logic signed [RESULT_WIDTH-1:0] value_nxt, value_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || m_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    ay       = (XW-1)'(y[XW-1] ? -y : y);
    d        = $signed({1'b0, ay}) - ONE_Y;
    kk_nxt   = 37'(d) * C_REF;
    k_nxt    = 37'(38'(kk_r) + OFFS);
    pplo_nxt = 42'(yg_r) * 42'($signed({1'b0, k_r[17:0]}));
    pphi_nxt = 42'(yg_r) * 42'($signed({1'b0, k_r[36:18]}));
    z_nxt    = (60'(pphi_r) <<< 18) + 60'(pplo_r);
    rz       = (z_r + HALF) >>> SH;
    if (rz > LIM) begin
      value_nxt = RESULT_WIDTH'(LIM);
    end else if (rz < -LIM) begin
      value_nxt = RESULT_WIDTH'(-LIM);
    end else begin
      value_nxt = RESULT_WIDTH'(rz);
    end
  end

  assign s_ready = en[0];
  assign m_valid = v_r[NS-1];
  assign value   = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= s_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kk_r <= kk_nxt;
      yf_r <= y;
    end
    if (en[1]) begin
      k_r  <= k_nxt;
      yg_r <= yf_r;
    end
    if (en[2]) begin
      pplo_r <= pplo_nxt;
      pphi_r <= pphi_nxt;
    end
    if (en[3]) begin
      z_r <= z_nxt;
    end
    if (en[4]) begin
      value_r <= value_nxt;
    end
  end

endmodule
